/* hdl/kmpc_pkg.sv */
// Shared types and constants for the key matrix press classifier.
package kmpc_pkg;

   localparam int ROWS = 3;
   localparam int COLS = 2;
   localparam int ROW_W = 2;
   localparam int COL_W = 1;
   localparam int CTR_W = 16;
   localparam int THR_W = 16;
   localparam int KIND_W = 2;
   localparam int EVT_PER_ITEM = 2;
   localparam int EVT_CNT_W = 2;
   localparam int EVQ_DEPTH = 4;
   localparam int EVQ_CNT_W = 3;
   localparam int CSR_ADDR_W = 1;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [THR_W-1:0] SHORT_RESET = 16'd500;
   localparam logic [THR_W-1:0] LONG_RESET = 16'd8000;
   localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

   localparam logic [CSR_ADDR_W-1:0] REG_SHORT_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_LONG_THRESHOLD = 1'd1;

   typedef enum logic [KIND_W-1:0] {
      EV_SHORT = 2'd0,
      EV_LONG = 2'd1,
      EV_MISFIRE = 2'd2
   } kmpc_kind_type;

   typedef logic [COLS-1:0][CTR_W-1:0] kmpc_row_ctr_type;

   typedef struct packed {
      logic last;
      kmpc_kind_type event_kind;
      logic [COL_W-1:0] key_col;
      logic [ROW_W-1:0] key_row;
   } kmpc_evt_type;

endpackage

/* hdl/kmpc_ctr_mem.sv */
// Hold counter memory, one row of counters per entry, with write-first read bypass.
module kmpc_ctr_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [kmpc_pkg::ROW_W-1:0]  rd_addr,
   output kmpc_pkg::kmpc_row_ctr_type  rd_data,
   input  logic                        wr_en,
   input  logic [kmpc_pkg::ROW_W-1:0]  wr_addr,
   input  kmpc_pkg::kmpc_row_ctr_type  wr_data
);
   import kmpc_pkg::*;

   kmpc_row_ctr_type mem [ROWS];
   logic [ROWS-1:0] row_vld_ff;
   kmpc_row_ctr_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (row_vld_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kmpc_update.sv */
// Per-row counter update and event classification for one scanned row.
module kmpc_update (
   input  logic [kmpc_pkg::ROW_W-1:0]                       row,
   input  logic [kmpc_pkg::COLS-1:0]                        col_levels,
   input  kmpc_pkg::kmpc_row_ctr_type                       ctr_cur,
   input  logic [kmpc_pkg::THR_W-1:0]                       short_thr,
   input  logic [kmpc_pkg::THR_W-1:0]                       long_thr,
   output kmpc_pkg::kmpc_row_ctr_type                       ctr_new,
   output kmpc_pkg::kmpc_evt_type [kmpc_pkg::EVT_PER_ITEM-1:0] evt,
   output logic [kmpc_pkg::EVT_CNT_W-1:0]                   evt_cnt
);
   import kmpc_pkg::*;

   logic [COLS-1:0] fire;
   kmpc_kind_type kind [COLS];
   logic [CTR_W-1:0] inc;

   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         inc = ctr_cur[c] + 1'b1;
         fire[c] = 1'b0;
         kind[c] = EV_SHORT;
         ctr_new[c] = ctr_cur[c];
         if (!col_levels[c]) begin
            if (ctr_cur[c] != CTR_MAX) begin
               ctr_new[c] = inc;
               if (inc == short_thr) begin
                  fire[c] = 1'b1;
                  kind[c] = EV_SHORT;
               end else if (inc == long_thr) begin
                  fire[c] = 1'b1;
                  kind[c] = EV_LONG;
               end
            end
         end else begin
            ctr_new[c] = '0;
            if ((ctr_cur[c] != '0) && (ctr_cur[c] < short_thr)) begin
               fire[c] = 1'b1;
               kind[c] = EV_MISFIRE;
            end
         end
      end
   end

   always_comb begin
      evt[0].key_row = row;
      evt[1].key_row = row;
      evt[1].key_col = COL_W'(1);
      evt[1].event_kind = kind[1];
      evt[1].last = 1'b1;
      if (fire[0]) begin
         evt[0].key_col = COL_W'(0);
         evt[0].event_kind = kind[0];
         evt[0].last = !fire[1];
      end else begin
         evt[0].key_col = COL_W'(1);
         evt[0].event_kind = kind[1];
         evt[0].last = 1'b1;
      end
      evt_cnt = EVT_CNT_W'(fire[0]) + EVT_CNT_W'(fire[1]);
   end

endmodule

/* hdl/kmpc_evt_queue.sv */
// Event queue that takes up to two events per cycle and hands out one per transaction.
module kmpc_evt_queue (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic [kmpc_pkg::EVT_CNT_W-1:0]                  push_cnt,
   input  kmpc_pkg::kmpc_evt_type [kmpc_pkg::EVT_PER_ITEM-1:0] push_evt,
   input  logic                                            pop_ready,
   output logic                                            head_vld,
   output kmpc_pkg::kmpc_evt_type                          head_evt,
   output logic [kmpc_pkg::EVQ_CNT_W-1:0]                  fill
);
   import kmpc_pkg::*;

   kmpc_evt_type q_ff [EVQ_DEPTH];
   kmpc_evt_type q_in [EVQ_DEPTH];
   logic [EVQ_CNT_W-1:0] cnt_ff;
   logic [EVQ_CNT_W-1:0] cnt_in;
   logic [EVQ_CNT_W-1:0] base;
   logic pop;

   always_comb begin
      pop = (cnt_ff != '0) && pop_ready;
      base = cnt_ff - EVQ_CNT_W'(pop);
      for (int i = 0; i < EVQ_DEPTH; i++) begin
         q_in[i] = q_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < EVQ_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i + 1];
         end
      end
      for (int i = 0; i < EVQ_DEPTH; i++) begin
         if ((push_cnt != '0) && (EVQ_CNT_W'(i) == base)) begin
            q_in[i] = push_evt[0];
         end
         if ((push_cnt == EVT_CNT_W'(2)) && (EVQ_CNT_W'(i) == base + 1'b1)) begin
            q_in[i] = push_evt[1];
         end
      end
      cnt_in = base + EVQ_CNT_W'(push_cnt);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign head_vld = (cnt_ff != '0);
   assign head_evt = q_ff[0];
   assign fill = cnt_ff;

endmodule

/* hdl/key_matrix_press_classifier.sv */
// Top level of the key matrix press classifier: stream ports, thresholds and row pipeline.
// One scanned row is taken per transaction; its counters are read from the counter memory
// in the cycle after acceptance and written back at the end of that cycle, so a row can be
// accepted every cycle while the event queue has room for two more events. Each row yields
// zero to two events, one per output transaction, so with two events per row the sustained
// row rate is limited by the single-event output port. An accepted row is registered in
// the row stage and its events in the event queue before they reach the output. Rows numbered
// three or higher are accepted and dropped without any event.
module key_matrix_press_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [kmpc_pkg::REQ_DATA_W-1:0]      req_tdata,  // row, col_levels
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [kmpc_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // key_row, key_col
   output logic [kmpc_pkg::KIND_W-1:0]          rsp_tuser,  // event_kind
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [kmpc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [kmpc_pkg::THR_W-1:0]           csr_wdata
);
   import kmpc_pkg::*;

   logic [THR_W-1:0] short_thr_ff;
   logic [THR_W-1:0] long_thr_ff;
   logic s1_vld_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COLS-1:0] s1_lvl_ff;

   logic [ROW_W-1:0] req_row;
   logic [COLS-1:0] req_lvl;
   logic req_take;
   logic row_ok;
   logic [EVQ_CNT_W:0] room_need;

   kmpc_row_ctr_type ctr_cur;
   kmpc_row_ctr_type ctr_new;
   kmpc_evt_type [EVT_PER_ITEM-1:0] upd_evt;
   logic [EVT_CNT_W-1:0] upd_cnt;
   logic [EVT_CNT_W-1:0] push_cnt;
   logic [EVQ_CNT_W-1:0] q_fill;
   kmpc_evt_type head_evt;

   assign req_row = req_tdata[ROW_W-1:0];
   assign req_lvl = req_tdata[ROW_W+COLS-1:ROW_W];
   assign row_ok = (req_row < ROW_W'(ROWS));
   assign room_need = {1'b0, q_fill} + (s1_vld_ff ? (EVQ_CNT_W+1)'(EVT_PER_ITEM) : '0);
   assign req_tready = (room_need <= (EVQ_CNT_W+1)'(EVQ_DEPTH - EVT_PER_ITEM));
   assign req_take = req_tvalid && req_tready && row_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_thr_ff <= SHORT_RESET;
         long_thr_ff <= LONG_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SHORT_THRESHOLD: short_thr_ff <= csr_wdata;
            REG_LONG_THRESHOLD:  long_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff <= req_row;
      s1_lvl_ff <= req_lvl;
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_take;
      end
   end

   kmpc_ctr_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (req_row),
      .rd_data (ctr_cur),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_row_ff),
      .wr_data (ctr_new)
   );

   kmpc_update u_update (
      .row        (s1_row_ff),
      .col_levels (s1_lvl_ff),
      .ctr_cur    (ctr_cur),
      .short_thr  (short_thr_ff),
      .long_thr   (long_thr_ff),
      .ctr_new    (ctr_new),
      .evt        (upd_evt),
      .evt_cnt    (upd_cnt)
   );

   assign push_cnt = s1_vld_ff ? upd_cnt : '0;

   kmpc_evt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_evt  (upd_evt),
      .pop_ready (rsp_tready),
      .head_vld  (rsp_tvalid),
      .head_evt  (head_evt),
      .fill      (q_fill)
   );

   assign rsp_tdata = {{(RSP_DATA_W - ROW_W - COL_W){1'b0}},
                       head_evt.key_col, head_evt.key_row};
   assign rsp_tuser = head_evt.event_kind;
   assign rsp_tlast = head_evt.last;

   a_s1_from_accept: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $past(req_tvalid && req_tready))
      else $error("row stage valid without an accepted transaction");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> ({1'b0, q_fill} + (EVQ_CNT_W+1)'(EVT_PER_ITEM)
                     <= (EVQ_CNT_W+1)'(EVQ_DEPTH)))
      else $error("event queue lacks room for a row in flight");

   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      ((push_cnt == EVT_CNT_W'(1)) |-> upd_evt[0].last) and
      ((push_cnt == EVT_CNT_W'(2)) |-> (!upd_evt[0].last && upd_evt[1].last)))
      else $error("last flag misplaced on pushed events");

endmodule

/* bench/key_matrix_press_classifier_tb.sv */
// Self-checking testbench for the key matrix press classifier with a built-in event predictor.
`timescale 1ns / 1ps

module key_matrix_press_classifier_tb;
   import kmpc_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE_CYCLES = 8;

   class press_scoreboard;
      logic [CTR_W-1:0] hold_count [ROWS*COLS];
      logic [THR_W-1:0] short_thr;
      logic [THR_W-1:0] long_thr;
      kmpc_evt_type expected_events [$];
      int errors;

      function new();
         foreach (hold_count[i]) hold_count[i] = '0;
         short_thr = SHORT_RESET;
         long_thr = LONG_RESET;
         errors = 0;
      endfunction

      function void set_threshold(logic [CSR_ADDR_W-1:0] addr, logic [THR_W-1:0] value);
         if (addr == REG_SHORT_THRESHOLD) short_thr = value;
         else if (addr == REG_LONG_THRESHOLD) long_thr = value;
      endfunction

      function void push_event(logic [ROW_W-1:0] r, int c, kmpc_kind_type kind);
         kmpc_evt_type ev;
         ev.key_row = r;
         ev.key_col = c[COL_W-1:0];
         ev.event_kind = kind;
         ev.last = 1'b0;
         expected_events.push_back(ev);
      endfunction

      // Counts presses of one scanned row and queues the events it raises.
      function void note_row(logic [REQ_DATA_W-1:0] data);
         logic [ROW_W-1:0] r;
         logic [COLS-1:0] levels;
         int idx;
         int queued;
         r = data[ROW_W-1:0];
         levels = data[ROW_W +: COLS];
         queued = expected_events.size();
         if (r >= ROWS) return;
         for (int c = 0; c < COLS; c++) begin
            idx = r * COLS + c;
            if (!levels[c]) begin
               if (hold_count[idx] != CTR_MAX) begin
                  hold_count[idx] = hold_count[idx] + 1'b1;
                  if (hold_count[idx] == short_thr) push_event(r, c, EV_SHORT);
                  else if (hold_count[idx] == long_thr) push_event(r, c, EV_LONG);
               end
            end else begin
               if (hold_count[idx] != 0 && hold_count[idx] < short_thr)
                  push_event(r, c, EV_MISFIRE);
               hold_count[idx] = '0;
            end
         end
         if (expected_events.size() > queued)
            expected_events[expected_events.size()-1].last = 1'b1;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_event(logic [RSP_DATA_W-1:0] data, logic [KIND_W-1:0] user, logic tlast);
         kmpc_evt_type ev;
         if (expected_events.size() == 0) begin
            report($sformatf("event with nothing expected, tdata=%h tuser=%h tlast=%b",
               data, user, tlast));
         end else begin
            ev = expected_events.pop_front();
            if (data[ROW_W-1:0] !== ev.key_row)
               report($sformatf("key_row %0d, expected %0d", data[ROW_W-1:0], ev.key_row));
            if (data[ROW_W +: COL_W] !== ev.key_col)
               report($sformatf("key_col %0d, expected %0d", data[ROW_W +: COL_W],
                  ev.key_col));
            if (user !== ev.event_kind)
               report($sformatf("event_kind %0d, expected %0d", user, ev.event_kind));
            if (tlast !== ev.last)
               report($sformatf("tlast %b, expected %b", tlast, ev.last));
            if (data[RSP_DATA_W-1:ROW_W+COL_W] !== '0)
               report($sformatf("nonzero padding in tdata %h", data));
         end
      endtask
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [THR_W-1:0] csr_wdata = '0;

   press_scoreboard events_sb = new();
   bit req_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   int stall_left = 0;
   int cycles = 0;
   logic [COLS-1:0] held [ROWS];

   key_matrix_press_classifier dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (rsp_gaps && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      rsp_tready <= !reset && stall_left == 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) events_sb.note_row(req_tdata);
         if (rsp_tvalid && rsp_tready) events_sb.check_event(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   task automatic send_row(input logic [ROW_W-1:0] r, input logic [COLS-1:0] levels);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - ROW_W - COLS){1'b0}}, levels, r};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (events_sb.expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_thresholds(input logic [THR_W-1:0] short_value,
                                 input logic [THR_W-1:0] long_value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= REG_SHORT_THRESHOLD;
      csr_wdata <= short_value;
      @(posedge clock);
      events_sb.set_threshold(REG_SHORT_THRESHOLD, short_value);
      csr_addr <= REG_LONG_THRESHOLD;
      csr_wdata <= long_value;
      @(posedge clock);
      events_sb.set_threshold(REG_LONG_THRESHOLD, long_value);
      csr_we <= 1'b0;
   endtask

   // Each row keeps a pressed mask that flips now and then, so keys are held for runs of scans.
   task automatic send_random_row();
      logic [ROW_W-1:0] r;
      logic [COLS-1:0] levels;
      r = ($urandom_range(0, 15) == 0) ? ROW_W'(3) : ROW_W'($urandom_range(0, ROWS-1));
      if (r >= ROWS || $urandom_range(0, 9) == 0) begin
         levels = COLS'($urandom);
      end else begin
         for (int c = 0; c < COLS; c++)
            if ($urandom_range(0, 5) == 0) held[r][c] = !held[r][c];
         levels = ~held[r];
      end
      send_row(r, levels);
   endtask

   initial begin
      logic [THR_W-1:0] s_thr;
      logic [THR_W-1:0] l_thr;
      int drain;
      foreach (held[i]) held[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset thresholds: ignored rows and early releases that count as misfires.
      send_row(2'd3, 2'b00);
      send_row(2'd3, 2'b11);
      send_row(2'd0, 2'b00);
      send_row(2'd0, 2'b11);
      send_row(2'd1, 2'b10);
      send_row(2'd1, 2'b01);
      send_row(2'd2, 2'b00);
      send_row(2'd2, 2'b11);
      send_row(2'd1, 2'b11);
      wait_idle();

      set_thresholds(16'd2, 16'd3);
      repeat (4) send_row(2'd0, 2'b00);
      send_row(2'd0, 2'b11);
      wait_idle();

      // Equal thresholds give only the short press.
      set_thresholds(16'd2, 16'd2);
      repeat (2) send_row(2'd1, 2'b00);
      send_row(2'd1, 2'b11);
      wait_idle();

      // Long threshold below the short one.
      set_thresholds(16'd3, 16'd1);
      repeat (3) send_row(2'd2, 2'b10);
      send_row(2'd2, 2'b11);
      wait_idle();

      // A zero short threshold: no misfire on release.
      set_thresholds(16'd0, 16'd2);
      repeat (2) send_row(2'd0, 2'b01);
      send_row(2'd0, 2'b11);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         s_thr = THR_W'($urandom_range(1, 6));
         l_thr = THR_W'($urandom_range(1, 12));
         case (phase)
            1: l_thr = s_thr;
            2: begin
               s_thr = THR_W'($urandom_range(5, 10));
               l_thr = THR_W'($urandom_range(1, 4));
            end
            3: s_thr = '0;
            4: l_thr = '0;
            5: begin
               s_thr = 16'd1;
               l_thr = 16'hFFFF;
            end
            6: begin
               s_thr = 16'hFFFF;
               l_thr = 16'hFFFF;
            end
            default: ;
         endcase
         set_thresholds(s_thr, l_thr);
         req_gaps = phase < 7 && $urandom_range(0, 3) != 0;
         rsp_gaps = phase < 7 && $urandom_range(0, 3) != 0;
         repeat (106) send_random_row();
         wait_idle();
      end

      drain = 0;
      while (events_sb.expected_events.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (events_sb.expected_events.size() != 0)
         events_sb.report($sformatf("%0d expected events never arrived",
            events_sb.expected_events.size()));
      if (events_sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
